/* design/sitda_pkg.sv */
package sitda_pkg;

  // Width of the integer that is converted (sign bit included)
  localparam int WORD_BITS  = 32;
  // Bits of the input stream word
  localparam int VALUE_BITS = 32;
  // Decimal digits needed for the largest magnitude, 2^(WORD_BITS-1)
  localparam int DIGITS     = (WORD_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = DIGITS * 4;
  localparam int CNT_W      = $clog2(WORD_BITS);
  localparam int NDIG_W     = $clog2(DIGITS + 1);

  // Depth of the queue between the front and the back
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;

  // One classified number: sign and unsigned magnitude
  typedef struct packed {
    logic                 neg;
    logic [WORD_BITS-1:0] mag;
  } item_t;

endpackage

/* design/sitda_front.sv */
module sitda_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sitda_pkg::VALUE_BITS-1:0] in_tdata,   // [31:0] value
  output logic                             item_valid,
  input  logic                             item_ready,
  output sitda_pkg::item_t                 item
);
  import sitda_pkg::*;

  logic                 valid_r;
  item_t                item_r;
  logic [WORD_BITS-1:0] raw;
  logic                 raw_neg;

  // sign split; two's complement negate keeps the most negative value exact
  assign raw     = in_tdata[WORD_BITS-1:0];
  assign raw_neg = raw[WORD_BITS-1];

  assign in_tready  = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  // holding stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      item_r.neg <= raw_neg;
      item_r.mag <= raw_neg ? (~raw + {{(WORD_BITS-1){1'b0}}, 1'b1}) : raw;
    end
  end

endmodule

/* design/sitda_queue.sv */
module sitda_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  sitda_pkg::item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sitda_pkg::item_t pop_item
);
  import sitda_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer wrap
  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    next_ptr = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= next_ptr(wptr_r);
      if (pop)  rptr_r <= next_ptr(rptr_r);
      if (push && !pop) count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
    if (push) mem_r[wptr_r] <= push_item;
  end

endmodule

/* design/sitda_back.sv */
module sitda_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  sitda_pkg::item_t item,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,   // [7:0] character
  output logic             out_tlast    // last
);
  import sitda_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t               state_r;
  logic                 neg_r;
  logic [WORD_BITS-1:0] mag_r;
  logic [BCD_W-1:0]     bcd_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [NDIG_W-1:0]    ndig_r;
  logic                 out_valid_r;
  logic [7:0]           out_data_r;
  logic                 out_last_r;

  logic [BCD_W-1:0]     bcd_adj;
  logic [3:0]           top_digit;
  logic                 slot_free;
  logic                 emit_go;

  assign item_ready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign top_digit  = bcd_r[BCD_W-1 -: 4];
  assign slot_free  = !out_valid_r || out_tready;
  // a character is loaded into the output register this cycle
  assign emit_go    = slot_free && (state_r == ST_SIGN || state_r == ST_EMIT);

  // double-dabble correction: add 3 to every digit of 5 or more
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      bcd_adj[d*4 +: 4] = (bcd_r[d*4 +: 4] >= 4'd5) ? bcd_r[d*4 +: 4] + 4'd3
                                                     : bcd_r[d*4 +: 4];
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (item_valid) begin
            neg_r   <= item.neg;
            mag_r   <= item.mag;
            bcd_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          // shift one magnitude bit into the digits
          bcd_r <= {bcd_adj[BCD_W-2:0], mag_r[WORD_BITS-1]};
          mag_r <= {mag_r[WORD_BITS-2:0], 1'b0};
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(WORD_BITS - 1)) begin
            ndig_r  <= NDIG_W'(DIGITS);
            state_r <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zeros, keep at least one digit
          if (top_digit == 4'd0 && ndig_r != NDIG_W'(1)) begin
            bcd_r  <= {bcd_r[BCD_W-5:0], 4'd0};
            ndig_r <= ndig_r - NDIG_W'(1);
          end else begin
            state_r <= neg_r ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            out_data_r  <= CH_MINUS;
            out_last_r  <= 1'b0;
            state_r     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_data_r  <= CH_ZERO + {4'd0, top_digit};
            out_last_r  <= (ndig_r == NDIG_W'(1));
            bcd_r       <= {bcd_r[BCD_W-5:0], 4'd0};
            ndig_r      <= ndig_r - NDIG_W'(1);
            if (ndig_r == NDIG_W'(1)) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // emission never runs out of digits
  a_emit_ndig: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (ndig_r != '0))
    else $error("emit state with no digits left");

  // digits stay decimal once conversion is done
  a_digit_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (top_digit <= 4'd9))
    else $error("non-decimal digit at emission");

  // the sign goes out ahead of the digits and never ends the text
  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIGN && slot_free) |=>
      (out_valid_r && out_data_r == CH_MINUS && !out_last_r && state_r == ST_EMIT))
    else $error("minus sign not transferred correctly");

endmodule

/* design/signed_int_to_decimal_ascii.sv */
// Converts a signed 32-bit two's complement integer into its decimal text,
// one ASCII byte per output transfer, most significant character first: a
// minus sign for negative values, then the digits without leading zeros
// (zero gives "0"); tlast marks the final character, the most negative value
// is exact. A number is taken from the queue, converted by bit-serial
// shift-and-add-3 (one magnitude bit per step), stripped of leading zeros
// and then sent one character per cycle while the output is not stalled
// (1 to 11 characters). The back end takes no new number until it has
// loaded the last character of the current one into its output register.
// A two-entry queue lets new numbers be taken while one is being converted.
module signed_int_to_decimal_ascii (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sitda_pkg::VALUE_BITS-1:0] in_tdata,   // [31:0] value
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [7:0] character
  output logic                             out_tlast   // last
);
  import sitda_pkg::*;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  sitda_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  sitda_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  sitda_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
